>>> hw/rtl/positional_list_engine_macros.svh
// Assertion helpers shared by the list engine RTL.
// Each macro expects signals named clk and rst in the using scope.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// ante |-> cons, checked every rising edge outside reset
`define PLE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante |=> cons
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// delayed implication from ante to cons
`define PLE_ASSERT_LAT2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`else

`define PLE_ASSERT_IMPL(lbl, ante, cons, msg)
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg)
`define PLE_ASSERT_LAT2(lbl, ante, cons, msg)

`endif

`endif

>>> hw/rtl/ple_pkg.sv
package ple_pkg;

  // request opcodes
  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_END   = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_POS   = 3'd3,
    OP_DEL_END   = 3'd4,
    OP_DEL_FRONT = 3'd5,
    OP_READ      = 3'd6
  } ple_op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } ple_status_t;

  // what the cell row does on the next edge
  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_INS  = 2'd1,
    CMD_DEL  = 2'd2,
    CMD_READ = 2'd3
  } ple_kind_t;

  typedef struct packed {
    logic        valid;
    ple_kind_t   kind;
    ple_status_t status;
  } ple_stage_t;

endpackage

>>> hw/rtl/ple_cell.sv
module ple_cell
  import ple_pkg::*;
#(
  parameter int IDX_W  = 6,
  parameter int WORD_W = 32,
  parameter int SLOT   = 0
) (
  input  logic              clk,
  input  ple_kind_t         kind,
  input  logic [IDX_W-1:0]  cmd_idx,
  input  logic [WORD_W-1:0] new_word,
  input  logic [WORD_W-1:0] left_word,
  input  logic [WORD_W-1:0] right_word,
  output logic [WORD_W-1:0] word
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(SLOT);

  // insert: slots past the gap take the left neighbor and the gap takes the new word; delete: take the right one
  always_ff @(posedge clk) begin
    unique case (kind)
      CMD_INS: begin
        if (MyIdx > cmd_idx) begin
          word <= left_word;
        end else if (MyIdx == cmd_idx) begin
          word <= new_word;
        end
      end
      CMD_DEL: begin
        if (MyIdx >= cmd_idx) begin
          word <= right_word;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hw/rtl/ple_ctrl.sv
module ple_ctrl
  import ple_pkg::*;
#(
  parameter int DEPTH  = 64,
  parameter int IDX_W  = 6,
  parameter int CNT_W  = 7,
  parameter int WORD_W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req,
  input  logic [2:0]        opcode,
  input  logic [CNT_W-1:0]  position,
  input  logic [WORD_W-1:0] value,
  output ple_stage_t        stage,
  output logic [IDX_W-1:0]  stage_idx,
  output logic [WORD_W-1:0] stage_word,
  output logic [CNT_W-1:0]  stage_len
);

  localparam logic [CNT_W-1:0] Full = CNT_W'(DEPTH);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  ple_kind_t        kind_next;
  ple_status_t      status_next;
  logic [IDX_W-1:0] idx_next;
  logic [CNT_W-1:0] pos_m1;
  logic [CNT_W:0]   count_p1;
  logic             is_full;
  logic             is_empty;
  logic             pos_bad;

  assign pos_m1   = position - CNT_W'(1);
  assign count_p1 = {1'b0, count} + (CNT_W + 1)'(1);
  assign is_full  = (count == Full);
  assign is_empty = (count == '0);
  assign pos_bad  = (position == '0) || (position > count);

  always_comb begin
    kind_next   = CMD_HOLD;
    status_next = ST_OK;
    idx_next    = '0;
    count_next  = count;
    unique case (opcode)
      OP_INS_FRONT: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          kind_next  = CMD_INS;
          count_next = count + CNT_W'(1);
        end
      end
      OP_INS_END: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          kind_next  = CMD_INS;
          idx_next   = count[IDX_W-1:0];
          count_next = count + CNT_W'(1);
        end
      end
      OP_INS_POS: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else if (position == '0) begin
          status_next = ST_BADPOS;
        end else if (is_empty) begin
          // any nonzero position lands at the front of an empty list
          kind_next  = CMD_INS;
          count_next = count + CNT_W'(1);
        end else if ({1'b0, position} > count_p1) begin
          status_next = ST_BADPOS;
        end else begin
          kind_next  = CMD_INS;
          idx_next   = pos_m1[IDX_W-1:0];
          count_next = count + CNT_W'(1);
        end
      end
      OP_DEL_POS, OP_READ: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else if (pos_bad) begin
          status_next = ST_BADPOS;
        end else if (opcode == OP_READ) begin
          kind_next = CMD_READ;
          idx_next  = pos_m1[IDX_W-1:0];
        end else begin
          kind_next  = CMD_DEL;
          idx_next   = pos_m1[IDX_W-1:0];
          count_next = count - CNT_W'(1);
        end
      end
      OP_DEL_END: begin
        // tail slot simply drops out of range, cells untouched
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      OP_DEL_FRONT: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          kind_next  = CMD_DEL;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      stage.valid  <= 1'b0;
      stage.kind   <= CMD_HOLD;
    end else begin
      stage.valid <= req;
      stage.kind  <= req ? kind_next : CMD_HOLD;
      if (req) begin
        count <= count_next;
      end
    end
    // payload needs no reset; it only matters while valid
    if (req) begin
      stage.status <= status_next;
      stage_idx    <= idx_next;
      stage_word   <= value;
      stage_len    <= count_next;
    end
  end

endmodule

>>> hw/rtl/positional_list_engine.sv
// Positional list engine: an ordered list of up to DEPTH signed words held in a
// row of cells, slot 0 at the front. A request is taken on any rising edge with
// start high and busy low; busy is high only while rst is asserted, so one
// request may be issued every clock. Its result (status, read_value, length)
// passes through the control stage and result register and is valid for exactly
// one cycle while done is high. The receiver cannot stall: results not captured
// in that cycle are gone. Results come back in request order, one per request.
`include "positional_list_engine_macros.svh"

module positional_list_engine
  import ple_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   opcode,
  input  logic [$clog2(DEPTH+1)-1:0]   position,
  input  logic signed [WORD_WIDTH-1:0] value,
  output logic                         done,
  output logic [1:0]                   status,
  output logic signed [WORD_WIDTH-1:0] read_value,
  output logic [$clog2(DEPTH+1)-1:0]   length
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Pipeline:
  //   control  request accepted; control decodes it against the word count,
  //            updates the count and registers a shift command for the row
  //   row      every cell loads itself, its left or right neighbor, or the
  //            new word in parallel; a read selects the addressed cell
  //   result   done high with the registered result
  // The count update in the control stage is the only dependency between
  // back-to-back requests, so throughput is one request per clock.

  logic             req;
  ple_stage_t       stg;
  logic [IDX_W-1:0] stg_idx;
  logic [WORD_WIDTH-1:0] stg_word;
  logic [CNT_W-1:0] stg_len;

  logic [WORD_WIDTH-1:0] cell_word  [DEPTH];
  logic [WORD_WIDTH-1:0] cell_left  [DEPTH];
  logic [WORD_WIDTH-1:0] cell_right [DEPTH];

  assign busy = rst;
  assign req  = start && !busy;

  ple_ctrl #(
    .DEPTH  (DEPTH),
    .IDX_W  (IDX_W),
    .CNT_W  (CNT_W),
    .WORD_W (WORD_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .opcode     (opcode),
    .position   (position),
    .value      (value),
    .stage      (stg),
    .stage_idx  (stg_idx),
    .stage_word (stg_word),
    .stage_len  (stg_len)
  );

  // Cell row. The ends of the row see their own word as the missing
  // neighbor; the last cell takes that path on every delete and keeps its word.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign cell_left[i] = cell_word[i];
    end else begin : g_mid_l
      assign cell_left[i] = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign cell_right[i] = cell_word[i];
    end else begin : g_mid_r
      assign cell_right[i] = cell_word[i+1];
    end

    ple_cell #(
      .IDX_W  (IDX_W),
      .WORD_W (WORD_WIDTH),
      .SLOT   (i)
    ) u_cell (
      .clk        (clk),
      .kind       (stg.kind),
      .cmd_idx    (stg_idx),
      .new_word   (stg_word),
      .left_word  (cell_left[i]),
      .right_word (cell_right[i]),
      .word       (cell_word[i])
    );
  end

  // Result register; reads sample the row as left by all earlier requests.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stg.valid;
    end
  end

  always_ff @(posedge clk) begin
    status     <= stg.status;
    length     <= stg_len;
    read_value <= (stg.kind == CMD_READ) ? cell_word[stg_idx] : '0;
  end

  `PLE_ASSERT_LAT2(a_req_done, req, done, "accepted request produced no result")
  `PLE_ASSERT_IMPL(a_done_src, done, $past(req, 2), "result without a request")
  `PLE_ASSERT_IMPL(a_len_max, done, length <= CNT_W'(DEPTH), "length beyond depth")
  `PLE_ASSERT_IMPL(a_rd_zero, done && (status != ST_OK), read_value == '0,
                   "read value not zero on failed request")
  `PLE_ASSERT_NEXT(a_del_end, req && (opcode == OP_DEL_END), stg.kind == CMD_HOLD,
                   "end delete moved the cell row")

endmodule
